// ===== sv/kscnt_pkg.sv =====
// Shared constants, types and count arithmetic for the keyed saturating count table.
package kscnt_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned UsedW        = $clog2(TableEntries + 1);
  localparam int unsigned KeyW         = 32;
  localparam int unsigned CntW         = 8;
  localparam int unsigned CmdW         = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD_KEY    = 3'd0,
    CMD_SUB_KEY    = 3'd1,
    CMD_SUB_SLOT   = 3'd2,
    CMD_REMOVE     = 3'd3,
    CMD_QUERY_KEY  = 3'd4,
    CMD_QUERY_SLOT = 3'd5,
    CMD_FIND_KEY   = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic            found;
    logic [CntW-1:0] count;
    logic [IdxW-1:0] slot;
    logic            drop;
  } result_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [CntW-1:0] count;
  } entry_t;

  // Saturating count add, clamps at all ones.
  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CntW] ? {CntW{1'b1}} : sum[CntW-1:0];
  endfunction

  // Saturating count subtract, clamps at zero.
  function automatic logic [CntW-1:0] sat_sub(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

// ===== sv/keyed_saturating_count_table_top.sv =====
// Keyed saturating count table: entry memory, scan/update sequencer and result register.
//
// Holds up to 16 (key, 8-bit count) entries in insertion order in one synchronous
// single-port-style memory (one read, one write per cycle, read data registered).
// One command is worked at a time; in_stall_o is high from the transfer until the
// result has been handed to the output register. Key commands (add, sub, query, find)
// scan the table from entry 0, each entry read and then compared, until the key is
// found or the used entries run out. Index commands read the addressed entry once;
// an out-of-range index, like an unused command, goes straight to the result. Remove
// reads the addressed entry and then moves every later entry down by one, each read
// and then written. The input opens in the cycle after the result is loaded. An
// append on a miss writes (key, amount) at the end of the table; with the table full
// the append is dropped and full_drop_o is set. Counts saturate at 255 and 0. The
// output register frees the input side as soon as a result is parked there, so a new
// command may start while the previous result is still stalled. Entry storage has no
// reset: only entries below the fill count are ever used, and those have been written.
module keyed_saturating_count_table_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [kscnt_pkg::CmdW-1:0]     cmd_i,
  input  logic [kscnt_pkg::KeyW-1:0]     item_key_i,
  input  logic [kscnt_pkg::IdxW-1:0]     slot_i,
  input  logic [kscnt_pkg::CntW-1:0]     amount_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           found_o,
  output logic [kscnt_pkg::CntW-1:0]     count_out_o,
  output logic [kscnt_pkg::IdxW-1:0]     slot_out_o,
  output logic                           full_drop_o,
  output logic [kscnt_pkg::UsedW-1:0]    entries_used_o
);

  // ---------------------------------------------------------------------------
  // Control and command registers
  // ---------------------------------------------------------------------------
  kscnt_pkg::state_e                 state_q, state_d;
  logic [kscnt_pkg::UsedW-1:0]       used_q, used_d;
  logic [kscnt_pkg::UsedW-1:0]       idx_q, idx_d;
  logic [kscnt_pkg::UsedW-1:0]       idx_nxt;
  logic                              out_valid_q;

  logic [kscnt_pkg::CmdW-1:0]        cmd_q;
  logic [kscnt_pkg::KeyW-1:0]        key_q;
  logic [kscnt_pkg::IdxW-1:0]        slot_q;
  logic [kscnt_pkg::CntW-1:0]        amt_q;

  kscnt_pkg::result_t                res_q, res_d;
  kscnt_pkg::result_t                out_res_q;
  logic [kscnt_pkg::UsedW-1:0]       out_used_q;

  logic                              in_xfer;
  logic                              out_load;

  // ---------------------------------------------------------------------------
  // Entry memory: one read port (registered data), one write port
  // ---------------------------------------------------------------------------
  kscnt_pkg::entry_t                 mem_q [kscnt_pkg::TableEntries];
  kscnt_pkg::entry_t                 rd_q;
  logic                              mem_we;
  logic [kscnt_pkg::IdxW-1:0]        mem_waddr;
  logic [kscnt_pkg::IdxW-1:0]        mem_raddr;
  kscnt_pkg::entry_t                 mem_wdata;

  logic [kscnt_pkg::CntW-1:0]        add_cnt;
  logic [kscnt_pkg::CntW-1:0]        sub_cnt;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  assign in_stall_o = (state_q != kscnt_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign idx_nxt    = idx_q + 1'b1;
  assign add_cnt    = kscnt_pkg::sat_add(rd_q.count, amt_q);
  assign sub_cnt    = kscnt_pkg::sat_sub(rd_q.count, amt_q);

  // ---------------------------------------------------------------------------
  // Sequencer: next state, memory accesses, result
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    used_d    = used_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q[kscnt_pkg::IdxW-1:0];
    mem_wdata = rd_q;
    mem_raddr = idx_q[kscnt_pkg::IdxW-1:0];
    out_load  = 1'b0;

    case (state_q)
      kscnt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          idx_d   = '0;
          state_d = kscnt_pkg::ST_READ;
        end
      end

      kscnt_pkg::ST_READ: begin
        case (cmd_q)
          kscnt_pkg::CMD_ADD_KEY, kscnt_pkg::CMD_SUB_KEY,
          kscnt_pkg::CMD_QUERY_KEY, kscnt_pkg::CMD_FIND_KEY: begin
            if (idx_q >= used_q) begin
              // scan ran off the used entries: key missing
              res_d   = '0;
              state_d = kscnt_pkg::ST_RESP;
              if (cmd_q == kscnt_pkg::CMD_ADD_KEY) begin
                if (used_q < kscnt_pkg::UsedW'(kscnt_pkg::TableEntries)) begin
                  mem_we          = 1'b1;
                  mem_waddr       = used_q[kscnt_pkg::IdxW-1:0];
                  mem_wdata.key   = key_q;
                  mem_wdata.count = amt_q;
                  used_d          = used_q + 1'b1;
                  res_d.count     = amt_q;
                end else begin
                  res_d.drop = 1'b1;
                end
              end
            end else begin
              mem_raddr = idx_q[kscnt_pkg::IdxW-1:0];
              state_d   = kscnt_pkg::ST_CHECK;
            end
          end
          kscnt_pkg::CMD_SUB_SLOT, kscnt_pkg::CMD_REMOVE,
          kscnt_pkg::CMD_QUERY_SLOT: begin
            if ({1'b0, slot_q} >= used_q) begin
              res_d   = '0;
              state_d = kscnt_pkg::ST_RESP;
            end else begin
              mem_raddr = slot_q;
              state_d   = kscnt_pkg::ST_CHECK;
            end
          end
          default: begin
            res_d   = '0;
            state_d = kscnt_pkg::ST_RESP;
          end
        endcase
      end

      kscnt_pkg::ST_CHECK: begin
        res_d.found = 1'b1;
        res_d.drop  = 1'b0;
        res_d.slot  = slot_q;
        res_d.count = rd_q.count;
        state_d     = kscnt_pkg::ST_RESP;
        case (cmd_q)
          kscnt_pkg::CMD_ADD_KEY, kscnt_pkg::CMD_SUB_KEY,
          kscnt_pkg::CMD_QUERY_KEY, kscnt_pkg::CMD_FIND_KEY: begin
            res_d.slot = idx_q[kscnt_pkg::IdxW-1:0];
            if (rd_q.key == key_q) begin
              if (cmd_q == kscnt_pkg::CMD_ADD_KEY) begin
                mem_we          = 1'b1;
                mem_wdata.count = add_cnt;
                res_d.count     = add_cnt;
              end else if (cmd_q == kscnt_pkg::CMD_SUB_KEY) begin
                mem_we          = 1'b1;
                mem_wdata.count = sub_cnt;
                res_d.count     = sub_cnt;
              end
            end else begin
              // no hit here, try the next entry
              res_d   = res_q;
              idx_d   = idx_nxt;
              state_d = kscnt_pkg::ST_READ;
            end
          end
          kscnt_pkg::CMD_SUB_SLOT: begin
            mem_we          = 1'b1;
            mem_waddr       = slot_q;
            mem_wdata.count = sub_cnt;
            res_d.count     = sub_cnt;
          end
          kscnt_pkg::CMD_REMOVE: begin
            idx_d   = {1'b0, slot_q};
            state_d = kscnt_pkg::ST_SHIFT_RD;
          end
          default: begin
          end
        endcase
      end

      kscnt_pkg::ST_SHIFT_RD: begin
        if (idx_nxt >= used_q) begin
          used_d  = used_q - 1'b1;
          state_d = kscnt_pkg::ST_RESP;
        end else begin
          mem_raddr = idx_nxt[kscnt_pkg::IdxW-1:0];
          state_d   = kscnt_pkg::ST_SHIFT_WR;
        end
      end

      kscnt_pkg::ST_SHIFT_WR: begin
        // entry idx+1 moves down to idx
        mem_we    = 1'b1;
        mem_waddr = idx_q[kscnt_pkg::IdxW-1:0];
        mem_wdata = rd_q;
        idx_d     = idx_nxt;
        state_d   = kscnt_pkg::ST_SHIFT_RD;
      end

      kscnt_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = kscnt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = kscnt_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kscnt_pkg::ST_IDLE;
      used_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= cmd_i;
      key_q  <= item_key_i;
      slot_q <= slot_i;
      amt_q  <= amount_i;
    end
    res_q <= res_d;
    if (out_load) begin
      out_res_q  <= res_q;
      out_used_q <= used_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_res_q.found;
  assign count_out_o    = out_res_q.count;
  assign slot_out_o     = out_res_q.slot;
  assign full_drop_o    = out_res_q.drop;
  assign entries_used_o = out_used_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= kscnt_pkg::UsedW'(kscnt_pkg::TableEntries))
    else $error("fill count beyond table size");

  a_write_below_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_waddr} < used_d))
    else $error("entry write outside the used part of the table");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_drop_o) |->
      (!found_o && entries_used_o == kscnt_pkg::UsedW'(kscnt_pkg::TableEntries)))
    else $error("append dropped while table had room");

  a_xfer_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == kscnt_pkg::ST_READ))
    else $error("accepted command did not start");

endmodule

// ===== sim/kscnt_result_checker.sv =====
// Channel monitor, table predictor and result comparator for the keyed count table.
module kscnt_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [kscnt_pkg::CmdW-1:0]     cmd_i,
  input  logic [kscnt_pkg::KeyW-1:0]     item_key_i,
  input  logic [kscnt_pkg::IdxW-1:0]     slot_i,
  input  logic [kscnt_pkg::CntW-1:0]     amount_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           found_i,
  input  logic [kscnt_pkg::CntW-1:0]     count_out_i,
  input  logic [kscnt_pkg::IdxW-1:0]     slot_out_i,
  input  logic                           full_drop_i,
  input  logic [kscnt_pkg::UsedW-1:0]    entries_used_i,
  output int unsigned                    n_errors_o,
  output int unsigned                    n_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        found;
    logic [kscnt_pkg::CntW-1:0]  count;
    logic [kscnt_pkg::IdxW-1:0]  slot;
    logic                        drop;
    logic [kscnt_pkg::UsedW-1:0] used;
  } table_result_t;

  // shadow copy of the table
  logic [kscnt_pkg::KeyW-1:0] shadow_key [kscnt_pkg::TableEntries];
  logic [kscnt_pkg::CntW-1:0] shadow_cnt [kscnt_pkg::TableEntries];
  int unsigned                shadow_used = 0;

  table_result_t   expected_q [$];
  int unsigned     mismatch_cnt = 0;

  // lowest matching position, -1 on a miss
  function automatic int lookup_key(input logic [kscnt_pkg::KeyW-1:0] k);
    for (int i = 0; i < int'(shadow_used); i++) begin
      if (shadow_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic logic [kscnt_pkg::CntW-1:0] clamp_add(
      input logic [kscnt_pkg::CntW-1:0] a, input logic [kscnt_pkg::CntW-1:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > 255) ? 8'hFF : s[kscnt_pkg::CntW-1:0];
  endfunction

  function automatic logic [kscnt_pkg::CntW-1:0] clamp_sub(
      input logic [kscnt_pkg::CntW-1:0] a, input logic [kscnt_pkg::CntW-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? 8'h00 : d[kscnt_pkg::CntW-1:0];
  endfunction

  // Applies one command to the shadow table and returns the result it should give.
  function automatic table_result_t apply_table_cmd(input logic [kscnt_pkg::CmdW-1:0] c,
                                                    input logic [kscnt_pkg::KeyW-1:0] k,
                                                    input logic [kscnt_pkg::IdxW-1:0] s,
                                                    input logic [kscnt_pkg::CntW-1:0] a);
    table_result_t r;
    int            hit;
    logic          slot_ok;
    r       = '0;
    hit     = -1;
    slot_ok = (int'(s) < int'(shadow_used));
    case (c)
      kscnt_pkg::CMD_ADD_KEY: begin
        hit = lookup_key(k);
        if (hit >= 0) begin
          shadow_cnt[hit] = clamp_add(shadow_cnt[hit], a);
          r.found = 1'b1;
          r.count = shadow_cnt[hit];
          r.slot  = hit[kscnt_pkg::IdxW-1:0];
        end else if (shadow_used < kscnt_pkg::TableEntries) begin
          shadow_key[shadow_used] = k;
          shadow_cnt[shadow_used] = a;
          shadow_used++;
          r.count = a;
        end else begin
          r.drop = 1'b1;
        end
      end
      kscnt_pkg::CMD_SUB_KEY: begin
        hit = lookup_key(k);
        if (hit >= 0) begin
          shadow_cnt[hit] = clamp_sub(shadow_cnt[hit], a);
          r.found = 1'b1;
          r.count = shadow_cnt[hit];
          r.slot  = hit[kscnt_pkg::IdxW-1:0];
        end
      end
      kscnt_pkg::CMD_SUB_SLOT: begin
        if (slot_ok) begin
          shadow_cnt[s] = clamp_sub(shadow_cnt[s], a);
          r.found = 1'b1;
          r.count = shadow_cnt[s];
          r.slot  = s;
        end
      end
      kscnt_pkg::CMD_REMOVE: begin
        if (slot_ok) begin
          r.found = 1'b1;
          r.count = shadow_cnt[s];
          r.slot  = s;
          for (int i = int'(s); i + 1 < int'(shadow_used); i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_cnt[i] = shadow_cnt[i+1];
          end
          shadow_used--;
        end
      end
      kscnt_pkg::CMD_QUERY_KEY, kscnt_pkg::CMD_FIND_KEY: begin
        hit = lookup_key(k);
        if (hit >= 0) begin
          r.found = 1'b1;
          r.count = shadow_cnt[hit];
          r.slot  = hit[kscnt_pkg::IdxW-1:0];
        end
      end
      kscnt_pkg::CMD_QUERY_SLOT: begin
        if (slot_ok) begin
          r.found = 1'b1;
          r.count = shadow_cnt[s];
          r.slot  = s;
        end
      end
      default: ;
    endcase
    r.used = shadow_used[kscnt_pkg::UsedW-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    table_result_t exp_r;
    if (rst_ni) begin
      // a result never leaves in the cycle its command arrives, so check it first
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no command outstanding: found=%0d count=%0d",
                 found_i, count_out_i);
          mismatch_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("found", 32'(exp_r.found), 32'(found_i));
          check_field("count_out", 32'(exp_r.count), 32'(count_out_i));
          check_field("slot_out", 32'(exp_r.slot), 32'(slot_out_i));
          check_field("full_drop", 32'(exp_r.drop), 32'(full_drop_i));
          check_field("entries_used", 32'(exp_r.used), 32'(entries_used_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(apply_table_cmd(cmd_i, item_key_i, slot_i, amount_i));
      end
      n_errors_o  <= mismatch_cnt;
      n_pending_o <= expected_q.size();
    end
  end

endmodule

// ===== sim/tb_keyed_saturating_count_table_top.sv =====
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
module tb_keyed_saturating_count_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  // cmd value outside the defined set; the block must treat it as a no-op
  localparam logic [kscnt_pkg::CmdW-1:0] CmdUnused = 3'd7;

  localparam int KeyPoolSize   = 28;    // more keys than entries, so the table fills
  localparam int NumRandom     = 1830;
  localparam int CalmStart     = 500;   // no idling on either side in [CalmStart, CalmEnd)
  localparam int CalmEnd       = 750;
  localparam int HoldoffAt     = 1100;  // receiver blocks for a long stretch here
  localparam int HoldoffCycles = 300;
  localparam int DrainAt       = 1500;  // sender waits for every result here
  localparam int SettleCycles  = 80;    // longer than the slowest item (full scan or full shift)
  localparam int WatchdogLimit = 4000;  // well above the hold-off and the slowest item

  // all inputs known from time zero
  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic [kscnt_pkg::CmdW-1:0]      cmd       = '0;
  logic [kscnt_pkg::KeyW-1:0]      item_key  = '0;
  logic [kscnt_pkg::IdxW-1:0]      slot      = '0;
  logic [kscnt_pkg::CntW-1:0]      amount    = '0;
  logic                            out_stall = 1'b0;

  logic                            in_stall;
  logic                            out_valid;
  logic                            found;
  logic [kscnt_pkg::CntW-1:0]      count_out;
  logic [kscnt_pkg::IdxW-1:0]      slot_out;
  logic                            full_drop;
  logic [kscnt_pkg::UsedW-1:0]     entries_used;

  int unsigned         n_errors;
  int unsigned         n_pending;

  // shared between the sender and the receiver process
  bit                  idle_on     = 1'b1;
  bit                  holdoff_req = 1'b0;

  logic [kscnt_pkg::KeyW-1:0] key_pool [KeyPoolSize];
  int unsigned                quiet_cycles = 0;

  always #10 clk = ~clk;

  keyed_saturating_count_table_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .item_key_i     (item_key),
    .slot_i         (slot),
    .amount_i       (amount),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .found_o        (found),
    .count_out_o    (count_out),
    .slot_out_o     (slot_out),
    .full_drop_o    (full_drop),
    .entries_used_o (entries_used)
  );

  kscnt_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .cmd_i          (cmd),
    .item_key_i     (item_key),
    .slot_i         (slot),
    .amount_i       (amount),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .found_i        (found),
    .count_out_i    (count_out),
    .slot_out_i     (slot_out),
    .full_drop_i    (full_drop),
    .entries_used_i (entries_used),
    .n_errors_o     (n_errors),
    .n_pending_o    (n_pending)
  );

  // Offers one command and returns at the edge where it transfers. An optional
  // idle gap goes in front; without one the payload changes at the transfer edge
  // itself and valid stays high, so back-to-back transfers are possible.
  task automatic send_cmd(input logic [kscnt_pkg::CmdW-1:0] c,
                          input logic [kscnt_pkg::KeyW-1:0] k,
                          input logic [kscnt_pkg::IdxW-1:0] s,
                          input logic [kscnt_pkg::CntW-1:0] a);
    if (idle_on && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    item_key <= k;
    slot     <= s;
    amount   <= a;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly keys from a small pool so adds, subs and queries hit; some fresh ones.
  function automatic logic [kscnt_pkg::KeyW-1:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(KeyPoolSize - 1)];
    return $urandom();
  endfunction

  // Amounts lean on the clamp points: zero, full scale and tiny steps.
  function automatic logic [kscnt_pkg::CntW-1:0] pick_amount();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    if (r < 30) return kscnt_pkg::CntW'($urandom_range(3, 1));
    return kscnt_pkg::CntW'($urandom_range(255));
  endfunction

  // add_w and rem_w in percent steer the fill level; a few percent are unused codes.
  function automatic logic [kscnt_pkg::CmdW-1:0] pick_cmd(input int add_w, input int rem_w);
    int r;
    r = $urandom_range(99);
    if (r < add_w) return kscnt_pkg::CMD_ADD_KEY;
    if (r < add_w + rem_w) return kscnt_pkg::CMD_REMOVE;
    if (r >= 97) return CmdUnused;
    case ($urandom_range(4))
      0:       return kscnt_pkg::CMD_SUB_KEY;
      1:       return kscnt_pkg::CMD_SUB_SLOT;
      2:       return kscnt_pkg::CMD_QUERY_KEY;
      3:       return kscnt_pkg::CMD_QUERY_SLOT;
      default: return kscnt_pkg::CMD_FIND_KEY;
    endcase
  endfunction

  // Receiver: random stalls, none during the calm stretch, and one long hold-off
  // on request so the block parks a result, takes one more command and then
  // stalls its input while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        out_stall <= 1'b1;
        repeat (HoldoffCycles) @(posedge clk);
        holdoff_req = 1'b0;
      end
      out_stall <= idle_on && ($urandom_range(99) < 18);
    end
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("[keyed_saturating_count_table_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int add_w;
    int rem_w;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h0000_0001;
    for (int i = 4; i < KeyPoolSize; i++) key_pool[i] = $urandom();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table misses, append of zero, both clamps, index ops,
    // unused command, out-of-range index, and removes that shift and empty.
    send_cmd(kscnt_pkg::CMD_QUERY_KEY,  32'h0000_0000, 4'd0,  8'd7);
    send_cmd(kscnt_pkg::CMD_QUERY_SLOT, 32'h0000_0000, 4'd0,  8'd0);
    send_cmd(kscnt_pkg::CMD_REMOVE,     32'h0000_0000, 4'd0,  8'd0);
    send_cmd(kscnt_pkg::CMD_SUB_SLOT,   32'h0000_0000, 4'd0,  8'd1);
    send_cmd(kscnt_pkg::CMD_SUB_KEY,    32'h0000_0000, 4'd0,  8'd1);
    send_cmd(kscnt_pkg::CMD_FIND_KEY,   32'hFFFF_FFFF, 4'd15, 8'd0);
    send_cmd(CmdUnused,                 32'hFFFF_FFFF, 4'd15, 8'd255);
    send_cmd(kscnt_pkg::CMD_ADD_KEY,    32'h0000_0000, 4'd0,  8'd0);
    send_cmd(kscnt_pkg::CMD_ADD_KEY,    32'hFFFF_FFFF, 4'd15, 8'd255);
    send_cmd(kscnt_pkg::CMD_ADD_KEY,    32'hFFFF_FFFF, 4'd0,  8'd1);
    send_cmd(kscnt_pkg::CMD_SUB_KEY,    32'h0000_0000, 4'd0,  8'd255);
    send_cmd(kscnt_pkg::CMD_ADD_KEY,    32'h0000_0000, 4'd0,  8'd200);
    send_cmd(kscnt_pkg::CMD_ADD_KEY,    32'h0000_0000, 4'd0,  8'd100);
    send_cmd(kscnt_pkg::CMD_SUB_SLOT,   32'h0000_0000, 4'd1,  8'd1);
    send_cmd(kscnt_pkg::CMD_SUB_SLOT,   32'h0000_0000, 4'd0,  8'd255);
    send_cmd(kscnt_pkg::CMD_ADD_KEY,    32'h8000_0000, 4'd0,  8'd42);
    send_cmd(kscnt_pkg::CMD_QUERY_SLOT, 32'h0000_0000, 4'd1,  8'd0);
    send_cmd(kscnt_pkg::CMD_QUERY_KEY,  32'hFFFF_FFFF, 4'd0,  8'd0);
    send_cmd(kscnt_pkg::CMD_FIND_KEY,   32'h8000_0000, 4'd0,  8'd0);
    send_cmd(kscnt_pkg::CMD_QUERY_SLOT, 32'h0000_0000, 4'd15, 8'd0);
    send_cmd(kscnt_pkg::CMD_REMOVE,     32'h0000_0000, 4'd0,  8'd0);
    send_cmd(kscnt_pkg::CMD_QUERY_SLOT, 32'h0000_0000, 4'd0,  8'd0);
    send_cmd(kscnt_pkg::CMD_REMOVE,     32'h0000_0000, 4'd1,  8'd0);
    send_cmd(kscnt_pkg::CMD_REMOVE,     32'h0000_0000, 4'd0,  8'd0);

    // Random: phases of 150 items alternate between filling, balanced and
    // draining the table, so full-table drops and long shifts both occur.
    for (int n = 0; n < NumRandom; n++) begin
      if (n == CalmStart) idle_on = 1'b0;
      if (n == CalmEnd)   idle_on = 1'b1;
      if (n == HoldoffAt) holdoff_req = 1'b1;
      if (n == DrainAt) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
      end
      case ((n / 150) % 3)
        0:       begin add_w = 50; rem_w = 8;  end
        1:       begin add_w = 25; rem_w = 15; end
        default: begin add_w = 12; rem_w = 30; end
      endcase
      send_cmd(pick_cmd(add_w, rem_w), pick_key(),
               kscnt_pkg::IdxW'($urandom_range(15)), pick_amount());
    end

    // wait out every result, then give a stray one time to show up
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (SettleCycles) @(posedge clk);

    if (n_errors == 0 && n_pending == 0) begin
      $display("[keyed_saturating_count_table_top] OK");
    end else begin
      $display("[keyed_saturating_count_table_top] ERROR");
    end
    $finish;
  end

endmodule
